[sv/text_console_writer_unit_assert.svh]
// ----------------------------------------------------------------------------
// text console writer assertion macros
// concurrent checks that compile away when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define TCW_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define TCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCW_ASSERT(lbl, clk, rst_n, ante, cons, msg)
`define TCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[sv/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// shared constants, command codes and types of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int COL_W       = 7;
  localparam int ROW_W       = 5;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int LAST_CELL   = CELLS - 1;
  localparam int LAST_COPY   = CELLS - COLUMNS - 1;
  localparam int FIRST_LAST_ROW = CELLS - COLUMNS;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] BLANK_CHAR = 8'd32;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] ATTR_RESET = 8'd15;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } tcw_opcode_t;

  typedef enum logic [2:0] {
    CMD_GLYPH,
    CMD_NEWLINE,
    CMD_RETURN,
    CMD_TAB,
    CMD_CLEAR,
    CMD_READ,
    CMD_NOP
  } tcw_cmd_kind_t;

  typedef struct packed {
    tcw_cmd_kind_t     kind;
    logic [7:0]        glyph;
    logic [ADDR_W-1:0] addr;
  } tcw_cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL
  } tcw_state_t;

endpackage

[sv/tcw_if.sv]
// ----------------------------------------------------------------------------
// tcw channel interfaces
// valid/ready channels for items, results and the attribute register
// ----------------------------------------------------------------------------
interface tcw_in_if;
  import tcw_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [7:0]       char_code;
  logic [COL_W-1:0] read_column;
  logic [ROW_W-1:0] read_row;
  modport source (output valid, opcode, char_code, read_column, read_row, input ready);
  modport sink (input valid, opcode, char_code, read_column, read_row, output ready);
endinterface

interface tcw_out_if;
  import tcw_pkg::*;
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] cursor_column;
  logic [ROW_W-1:0] cursor_row;
  logic             scrolled;
  logic [7:0]       cell_char;
  logic [7:0]       cell_attribute;
  modport source (output valid, cursor_column, cursor_row, scrolled, cell_char,
                  cell_attribute, input ready);
  modport sink (input valid, cursor_column, cursor_row, scrolled, cell_char,
                cell_attribute, output ready);
endinterface

interface tcw_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_attribute;
  modport source (output valid, text_attribute, input ready);
  modport sink (input valid, text_attribute, output ready);
endinterface

[sv/text_console_writer_unit.sv]
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Character-cell console of 80x25 16-bit cells (attribute high byte,
// character low byte) with a cursor, driven by put, clear and read
// transactions and returning one result per transaction. After reset the
// store is blanked by a pass over every cell during which input is held off;
// attribute writes are still taken. A decode stage and a two-entry command
// queue accept transactions while the executor is busy. The executor
// handles a put of a printable byte, newline, return or tab from its idle
// state, and a read through the single registered read port of the screen
// store. A clear blanks every cell and a put that scrolls makes 1920 cell
// copies, drains the copy pipeline and makes 80 blank writes, both bound
// by one store write per cycle.
// ----------------------------------------------------------------------------
module text_console_writer_unit (
  input  logic      clk,
  input  logic      rst_n,
  tcw_in_if.sink    in_ch,
  tcw_out_if.source out_ch,
  tcw_cfg_if.sink   cfg_ch
);
  import tcw_pkg::*;

  logic     init_done;
  logic     push_valid, push_ready;
  tcw_cmd_t push_cmd;
  logic     pop_valid, pop_ready;
  tcw_cmd_t pop_cmd;

  tcw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .init_done  (init_done),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  tcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  tcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop_ready (pop_ready),
    .cfg_ch    (cfg_ch),
    .out_ch    (out_ch),
    .init_done (init_done)
  );

endmodule

[sv/tcw_front.sv]
// ----------------------------------------------------------------------------
// tcw_front
// accepts input transactions, decodes them into console commands
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic              clk,
  input  logic              rst_n,
  tcw_in_if.sink            in_ch,
  input  logic              init_done,
  output logic              push_valid,
  output tcw_pkg::tcw_cmd_t push_cmd,
  input  logic              push_ready
);
  import tcw_pkg::*;

  logic     slot_vld_r, slot_vld_nxt;
  tcw_cmd_t slot_cmd_r;
  tcw_cmd_t cmd_dec;
  logic     accept;
  logic     read_in_range;

  assign in_ch.ready = init_done && (!slot_vld_r || push_ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_valid  = slot_vld_r;
  assign push_cmd    = slot_cmd_r;

  assign read_in_range = ({1'b0, in_ch.read_column} < (COL_W + 1)'(COLUMNS)) &&
                         ({1'b0, in_ch.read_row} < (ROW_W + 1)'(ROWS));

  always_comb begin
    cmd_dec.glyph = in_ch.char_code;
    cmd_dec.addr  = ADDR_W'(in_ch.read_row) * ADDR_W'(COLUMNS) + ADDR_W'(in_ch.read_column);
    cmd_dec.kind  = CMD_NOP;
    case (in_ch.opcode)
      OP_PUT: begin
        case (in_ch.char_code)
          CH_NEWLINE: cmd_dec.kind = CMD_NEWLINE;
          CH_RETURN:  cmd_dec.kind = CMD_RETURN;
          CH_TAB:     cmd_dec.kind = CMD_TAB;
          default:    cmd_dec.kind = CMD_GLYPH;
        endcase
      end
      OP_CLEAR: cmd_dec.kind = CMD_CLEAR;
      OP_READ:  cmd_dec.kind = read_in_range ? CMD_READ : CMD_NOP;
      default:  cmd_dec.kind = CMD_NOP;
    endcase
  end

  always_comb begin
    slot_vld_nxt = slot_vld_r;
    if (accept) begin
      slot_vld_nxt = 1'b1;
    end else if (push_ready) begin
      slot_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= 1'b0;
    end else begin
      slot_vld_r <= slot_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_cmd_r <= cmd_dec;
    end
  end

endmodule

[sv/tcw_queue.sv]
// ----------------------------------------------------------------------------
// tcw_queue
// short command queue between decode and execution
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  tcw_pkg::tcw_cmd_t push_cmd,
  output logic              push_ready,
  output logic              pop_valid,
  output tcw_pkg::tcw_cmd_t pop_cmd,
  input  logic              pop_ready
);
  import tcw_pkg::*;

  tcw_cmd_t          q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = cnt_r != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = q_mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[sv/tcw_back.sv]
// ----------------------------------------------------------------------------
// tcw_back
// executes console commands against the screen store and drives results
// ----------------------------------------------------------------------------
`include "text_console_writer_unit_assert.svh"

module tcw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  input  tcw_pkg::tcw_cmd_t pop_cmd,
  output logic              pop_ready,
  tcw_cfg_if.sink           cfg_ch,
  tcw_out_if.source         out_ch,
  output logic              init_done
);
  import tcw_pkg::*;

  logic [15:0]       screen_mem [CELLS];
  logic [15:0]       rd_data_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [15:0]       mem_wdata;

  tcw_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic              copy_done_r, copy_done_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic [7:0]        fill_attr_r, fill_attr_nxt;
  logic              fill_scroll_r, fill_scroll_nxt;
  logic [7:0]        attr_r;
  logic [COL_W-1:0]  cur_col_r, col_nxt;
  logic [ROW_W-1:0]  cur_row_r, row_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic              out_scr_r, out_scr_nxt;
  logic [7:0]        out_char_r, out_char_nxt;
  logic [7:0]        out_attr_r, out_attr_nxt;

  logic              emit, emit_scr;
  logic [7:0]        emit_char, emit_attr;
  logic [COL_W:0]    col_w;
  logic [ROW_W:0]    row_w;
  logic              is_move;

  assign init_done   = state_r != ST_INIT;
  assign pop_ready   = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cursor_column  = out_col_r;
  assign out_ch.cursor_row     = out_row_r;
  assign out_ch.scrolled       = out_scr_r;
  assign out_ch.cell_char      = out_char_r;
  assign out_ch.cell_attribute = out_attr_r;

  always_comb begin
    state_nxt       = state_r;
    ptr_nxt         = ptr_r;
    copy_done_nxt   = copy_done_r;
    wr_pend_nxt     = 1'b0;
    wr_addr_nxt     = wr_addr_r;
    fill_attr_nxt   = fill_attr_r;
    fill_scroll_nxt = fill_scroll_r;
    col_nxt         = cur_col_r;
    row_nxt         = cur_row_r;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    mem_raddr       = '0;
    emit            = 1'b0;
    emit_scr        = 1'b0;
    emit_char       = '0;
    emit_attr       = '0;
    col_w           = {1'b0, cur_col_r};
    row_w           = {1'b0, cur_row_r};
    is_move         = 1'b0;

    case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = {ATTR_RESET, BLANK_CHAR};
        if (ptr_r == ADDR_W'(LAST_CELL)) begin
          state_nxt = ST_IDLE;
          ptr_nxt   = '0;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (pop_valid && pop_ready) begin
          case (pop_cmd.kind)
            CMD_GLYPH: begin
              mem_we    = 1'b1;
              mem_waddr = ADDR_W'(cur_row_r) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_r);
              mem_wdata = {attr_r, pop_cmd.glyph};
              col_w     = {1'b0, cur_col_r} + 1'b1;
              is_move   = 1'b1;
            end
            CMD_NEWLINE: begin
              col_w   = '0;
              row_w   = {1'b0, cur_row_r} + 1'b1;
              is_move = 1'b1;
            end
            CMD_RETURN: begin
              col_w   = '0;
              is_move = 1'b1;
            end
            CMD_TAB: begin
              col_w   = ({1'b0, cur_col_r} + (COL_W + 1)'(8)) & ~(COL_W + 1)'(7);
              is_move = 1'b1;
            end
            CMD_CLEAR: begin
              col_nxt         = '0;
              row_nxt         = '0;
              ptr_nxt         = '0;
              fill_attr_nxt   = attr_r;
              fill_scroll_nxt = 1'b0;
              state_nxt       = ST_FILL;
            end
            CMD_READ: begin
              mem_re    = 1'b1;
              mem_raddr = pop_cmd.addr;
              state_nxt = ST_READ;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
          if (is_move) begin
            if (col_w >= (COL_W + 1)'(COLUMNS)) begin
              col_w = '0;
              row_w = row_w + 1'b1;
            end
            col_nxt = col_w[COL_W-1:0];
            if (row_w >= (ROW_W + 1)'(ROWS)) begin
              row_nxt         = ROW_W'(ROWS - 1);
              ptr_nxt         = '0;
              copy_done_nxt   = 1'b0;
              fill_attr_nxt   = attr_r;
              fill_scroll_nxt = 1'b1;
              state_nxt       = ST_COPY;
            end else begin
              row_nxt = row_w[ROW_W-1:0];
              emit    = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        emit      = 1'b1;
        emit_char = rd_data_r[7:0];
        emit_attr = rd_data_r[15:8];
        state_nxt = ST_IDLE;
      end
      ST_COPY: begin
        if (wr_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_r;
          mem_wdata = rd_data_r;
        end
        if (copy_done_r) begin
          ptr_nxt   = ADDR_W'(FIRST_LAST_ROW);
          state_nxt = ST_FILL;
        end else begin
          mem_re      = 1'b1;
          mem_raddr   = ptr_r + ADDR_W'(COLUMNS);
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = ptr_r;
          if (ptr_r == ADDR_W'(LAST_COPY)) begin
            copy_done_nxt = 1'b1;
          end else begin
            ptr_nxt = ptr_r + 1'b1;
          end
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = {fill_attr_r, BLANK_CHAR};
        if (ptr_r == ADDR_W'(LAST_CELL)) begin
          emit      = 1'b1;
          emit_scr  = fill_scroll_r;
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result slot, loaded only when free
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_scr_nxt   = out_scr_r;
    out_char_nxt  = out_char_r;
    out_attr_nxt  = out_attr_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_col_nxt   = col_nxt;
      out_row_nxt   = row_nxt;
      out_scr_nxt   = emit_scr;
      out_char_nxt  = emit_char;
      out_attr_nxt  = emit_attr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      ptr_r       <= '0;
      copy_done_r <= 1'b0;
      wr_pend_r   <= 1'b0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      attr_r      <= ATTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      copy_done_r <= copy_done_nxt;
      wr_pend_r   <= wr_pend_nxt;
      cur_col_r   <= col_nxt;
      cur_row_r   <= row_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        attr_r <= cfg_ch.text_attribute;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r     <= wr_addr_nxt;
    fill_attr_r   <= fill_attr_nxt;
    fill_scroll_r <= fill_scroll_nxt;
    out_col_r     <= out_col_nxt;
    out_row_r     <= out_row_nxt;
    out_scr_r     <= out_scr_nxt;
    out_char_r    <= out_char_nxt;
    out_attr_r    <= out_attr_nxt;
  end

  // screen store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= screen_mem[mem_raddr];
    end
  end

  `TCW_ASSERT(a_col_range, clk, rst_n, 1'b1, cur_col_r <= COL_W'(COLUMNS - 1), "cursor column out of range")
  `TCW_ASSERT(a_row_range, clk, rst_n, 1'b1, cur_row_r <= ROW_W'(ROWS - 1), "cursor row out of range")
  `TCW_ASSERT(a_pop_slot_free, clk, rst_n, pop_valid && pop_ready, !out_valid_r || out_ch.ready, "command taken while result slot busy")
  `TCW_ASSERT_NXT(a_read_emits, clk, rst_n, state_r == ST_READ, out_valid_r, "read finished without a result")
  `TCW_ASSERT(a_init_quiet, clk, rst_n, state_r == ST_INIT, !out_valid_r && !pop_ready, "activity during initial clear")

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text console writer testbench
// Drives put, clear and read transactions into the console and predicts the
// cursor, scroll flag and read cell of each result from its own copy of the
// screen. Directed checks of reset contents, control bytes and attribute
// extremes come first. Random text lines, tab runs and noise follow, with
// random idling on both channels, a long result hold-off and a full-rate
// stretch.
// ----------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] line;
    logic             scrolled;
    logic [7:0]       glyph;
    logic [7:0]       attr;
  } console_status_t;

  logic clk;
  logic rst_n;

  tcw_in_if  in_if ();
  tcw_out_if out_if ();
  tcw_cfg_if cfg_if ();

  text_console_writer_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  logic [15:0]     screen_model [CELLS];
  int unsigned     cur_col_model;
  int unsigned     cur_row_model;
  logic [7:0]      attr_model;
  console_status_t predicted_status_q [$];
  console_status_t want_status;

  bit no_idle;
  int hold_request;
  int hold_left;
  int items_sent;
  int results_checked;
  int error_count;
  int scroll_count;
  int clear_count;
  int read_count;
  int attr_writes;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #100000000;
    $display("timeout with %0d results outstanding", predicted_status_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // screen model
  function automatic void blank_from(int unsigned first);
    for (int i = first; i < CELLS; i++) screen_model[i] = {attr_model, BLANK_CHAR};
  endfunction

  function automatic console_status_t console_apply(logic [1:0] op, logic [7:0] ch,
                                                    logic [COL_W-1:0] rc,
                                                    logic [ROW_W-1:0] rr);
    console_status_t st;
    int unsigned c;
    int unsigned r;
    st = '0;
    case (op)
      OP_PUT: begin
        c = cur_col_model;
        r = cur_row_model;
        if (ch == CH_NEWLINE) begin
          c = 0;
          r++;
        end else if (ch == CH_RETURN) begin
          c = 0;
        end else if (ch == CH_TAB) begin
          c = (c + 8) & ~32'd7;
        end else begin
          screen_model[r * COLUMNS + c] = {attr_model, ch};
          c++;
        end
        if (c >= COLUMNS) begin
          c = 0;
          r++;
        end
        if (r >= ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
          blank_from(CELLS - COLUMNS);
          r = ROWS - 1;
          st.scrolled = 1'b1;
          scroll_count++;
        end
        cur_col_model = c;
        cur_row_model = r;
      end
      OP_CLEAR: begin
        blank_from(0);
        cur_col_model = 0;
        cur_row_model = 0;
        clear_count++;
      end
      OP_READ: begin
        read_count++;
        if (rc < COLUMNS && rr < ROWS) {st.attr, st.glyph} = screen_model[rr * COLUMNS + rc];
      end
      default: ;
    endcase
    st.column = cur_col_model[COL_W-1:0];
    st.line   = cur_row_model[ROW_W-1:0];
    return st;
  endfunction

  // result checking
  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("mismatch in %s of result %0d: expected %0d, got %0d", name,
                 results_checked, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (predicted_status_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) $display("result with no transaction outstanding");
      end else begin
        want_status = predicted_status_q.pop_front();
        check_field("cursor_column", 8'(want_status.column), 8'(out_if.cursor_column));
        check_field("cursor_row", 8'(want_status.line), 8'(out_if.cursor_row));
        check_field("scrolled", 8'(want_status.scrolled), 8'(out_if.scrolled));
        check_field("cell_char", want_status.glyph, out_if.cell_char);
        check_field("cell_attribute", want_status.attr, out_if.cell_attribute);
      end
      results_checked++;
    end
  end

  // result ready with random idling and long hold-offs
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(99) < 6) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // transaction driving
  task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                           input logic [COL_W-1:0] rc, input logic [ROW_W-1:0] rr);
    if (!no_idle && $urandom_range(99) < 6) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= op;
    in_if.char_code   <= ch;
    in_if.read_column <= rc;
    in_if.read_row    <= rr;
    do @(posedge clk); while (!in_if.ready);
    predicted_status_q.push_back(console_apply(op, ch, rc, rr));
    items_sent++;
  endtask

  task automatic put_byte(input logic [7:0] ch);
    send_item(OP_PUT, ch, COL_W'($urandom_range(127)), ROW_W'($urandom_range(31)));
  endtask

  task automatic read_cell(input int unsigned c, input int unsigned r);
    send_item(OP_READ, 8'($urandom_range(255)), c[COL_W-1:0], r[ROW_W-1:0]);
  endtask

  task automatic read_recent();
    read_cell(cur_col_model == 0 ? 0 : cur_col_model - 1, cur_row_model);
  endtask

  task automatic clear_screen();
    send_item(OP_CLEAR, 8'($urandom_range(255)), COL_W'($urandom_range(127)),
              ROW_W'($urandom_range(31)));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (predicted_status_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_attribute(input logic [7:0] value);
    wait_drained();
    cfg_if.valid          <= 1'b1;
    cfg_if.text_attribute <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    attr_model = value;
    attr_writes++;
  endtask

  function automatic logic [7:0] random_glyph();
    logic [7:0] g;
    do g = 8'($urandom_range(255)); while (g == CH_NEWLINE || g == CH_RETURN || g == CH_TAB);
    return g;
  endfunction

  // tests
  task automatic test_reset_contents();
    read_cell(0, 0);
    read_cell(COLUMNS - 1, ROWS - 1);
    read_cell(COLUMNS, 0);
    read_cell(0, ROWS);
  endtask

  task automatic test_char_codes();
    put_byte(8'h41);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h80);
    put_byte(8'h7F);
    put_byte(CH_TAB);
    put_byte(CH_RETURN);
    put_byte(CH_NEWLINE);
    send_item(OP_UNUSED, 8'hFF, 7'h7F, 5'h1F);
    read_cell(0, 0);
    read_cell(2, 0);
    read_cell(4, 0);
    read_cell(127, 31);
    clear_screen();
    read_cell(0, 0);
  endtask

  task automatic test_attribute_extremes();
    set_attribute(8'h00);
    put_byte(random_glyph());
    read_recent();
    clear_screen();
    read_cell(5, 5);
    set_attribute(8'hFF);
    put_byte(random_glyph());
    read_recent();
    put_byte(CH_NEWLINE);
  endtask

  task automatic test_text_lines(input int count);
    int stop_at;
    int len;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(70, 100) : $urandom_range(0, 12);
      repeat (len) begin
        put_byte(random_glyph());
        if ($urandom_range(5) == 0) read_recent();
      end
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: put_byte(CH_NEWLINE);
        6: begin
          put_byte(CH_RETURN);
          put_byte(CH_NEWLINE);
        end
        7: put_byte(CH_RETURN);
        8: repeat ($urandom_range(1, 4)) put_byte(CH_TAB);
        default: read_cell($urandom_range(COLUMNS - 1), $urandom_range(ROWS - 1));
      endcase
    end
  endtask

  task automatic test_tab_runs(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      repeat ($urandom_range(0, 6)) put_byte(random_glyph());
      repeat ($urandom_range(1, 11)) put_byte(CH_TAB);
      if ($urandom_range(2) == 0) read_recent();
    end
  endtask

  task automatic test_output_backpressure();
    wait_drained();
    hold_request = 400;
    @(posedge clk);
    repeat (12) put_byte(random_glyph());
    read_recent();
    wait_drained();
  endtask

  task automatic test_full_rate(input int count);
    no_idle = 1'b1;
    test_text_lines(count);
    wait_drained();
    no_idle = 1'b0;
  endtask

  task automatic test_random_items(input int count);
    repeat (count)
      send_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                COL_W'($urandom_range(127)), ROW_W'($urandom_range(31)));
  endtask

  initial begin
    rst_n                 = 1'b0;
    no_idle               = 1'b0;
    hold_request          = 0;
    hold_left             = 0;
    in_if.valid           = 1'b0;
    in_if.opcode          = OP_PUT;
    in_if.char_code       = '0;
    in_if.read_column     = '0;
    in_if.read_row        = '0;
    out_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.text_attribute = ATTR_RESET;
    attr_model            = ATTR_RESET;
    cur_col_model         = 0;
    cur_row_model         = 0;
    blank_from(0);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_contents();
    test_char_codes();
    test_attribute_extremes();
    test_text_lines(180);
    set_attribute(8'($urandom_range(255)));
    test_tab_runs(60);
    test_output_backpressure();
    set_attribute(8'($urandom_range(255)));
    test_full_rate(70);
    test_random_items(60);
    set_attribute(8'($urandom_range(255)));
    test_text_lines(150);
    wait_drained();

    $display("sent %0d transactions: %0d scrolls, %0d clears, %0d reads, %0d attribute writes",
             items_sent, scroll_count, clear_count, read_count, attr_writes);
    $display("checked %0d results with %0d errors", results_checked, error_count);
    if (error_count == 0 && predicted_status_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
